// ===== src/assert_macros.svh =====
// Assertion macros used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== src/nmea_rmc_pkg.sv =====
// Types, constants and helpers for the NMEA RMC time/date extractor
package nmea_rmc_pkg;

   localparam int CHAR_W    = 8;
   localparam int NUM_CHARS = 6;
   localparam int STORE_W   = CHAR_W * NUM_CHARS;
   localparam int LINE_LIMIT = 127;
   localparam int POS_W     = $clog2(LINE_LIMIT + 1);
   localparam int HEAD_LEN  = 6;
   localparam int IDX_W     = 3;
   localparam int COMMA_W   = 8;

   localparam logic [CHAR_W-1:0] CHAR_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [COMMA_W-1:0] TIME_FIELD = 8'd1;
   localparam logic [COMMA_W-1:0] DATE_FIELD = 8'd9;
   localparam logic [IDX_W-1:0]   LAST_SLOT  = 3'd5;
   localparam logic [STORE_W-1:0] STORE_RESET = 48'h3030_3030_3030;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_TIME = 2'd1,
      MODE_SKIP = 2'd2,
      MODE_DATE = 2'd3
   } capture_mode_type;

   typedef struct packed {
      logic [STORE_W-1:0] time_chars;
      logic [STORE_W-1:0] date_chars;
      logic               sentence_accepted;
   } result_type;

   // expected header "$GPRMC"
   function automatic logic [CHAR_W-1:0] head_char(input logic [IDX_W-1:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h24;
         3'd1:    ch = 8'h47;
         3'd2:    ch = 8'h50;
         3'd3:    ch = 8'h52;
         3'd4:    ch = 8'h4D;
         3'd5:    ch = 8'h43;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

   // slot 0 lands in the most significant byte
   function automatic logic [STORE_W-1:0] put_char(input logic [STORE_W-1:0] r,
                                                   input logic [IDX_W-1:0]   slot,
                                                   input logic [CHAR_W-1:0]  ch);
      logic [STORE_W-1:0] v;
      v = r;
      for (int i = 0; i < NUM_CHARS; i++) begin
         if (slot == IDX_W'(i)) begin
            v[(NUM_CHARS-1-i)*CHAR_W +: CHAR_W] = ch;
         end
      end
      return v;
   endfunction

endpackage

// ===== src/nmea_rmc_core.sv =====
// Per-byte sentence parser holding the line state and the time/date stores
`include "assert_macros.svh"
module nmea_rmc_core import nmea_rmc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] rx_byte,
   output result_type        result
);

   logic [POS_W-1:0]   pos_ff,   pos_in;
   logic               hm_ff,    hm_in;
   logic [COMMA_W-1:0] comma_ff, comma_in;
   logic               taken_ff, taken_in;
   capture_mode_type   mode_ff,  mode_in;
   logic [IDX_W-1:0]   idx_ff,   idx_in;
   logic               done_ff,  done_in;
   logic [STORE_W-1:0] time_ff,  time_in;
   logic [STORE_W-1:0] date_ff,  date_in;

   logic is_lf;
   assign is_lf = (rx_byte == CHAR_LF);

   always_comb begin
      pos_in   = pos_ff;
      hm_in    = hm_ff;
      comma_in = comma_ff;
      taken_in = taken_ff;
      mode_in  = mode_ff;
      idx_in   = idx_ff;
      done_in  = done_ff;
      time_in  = time_ff;
      date_in  = date_ff;
      if (step) begin
         if (is_lf) begin
            pos_in   = '0;
            hm_in    = 1'b1;
            comma_in = '0;
            taken_in = 1'b0;
            mode_in  = MODE_IDLE;
            idx_in   = '0;
            done_in  = 1'b0;
         end else if (pos_ff < POS_W'(LINE_LIMIT)) begin
            pos_in = pos_ff + POS_W'(1);
            if (pos_ff < POS_W'(HEAD_LEN)) begin
               if (rx_byte != head_char(pos_ff[IDX_W-1:0])) begin
                  hm_in = 1'b0;
               end
            end else if (hm_ff && !done_ff) begin
               unique case (mode_ff)
                  MODE_TIME: begin
                     time_in = put_char(time_ff, idx_ff, rx_byte);
                     if (idx_ff == LAST_SLOT) begin
                        idx_in  = '0;
                        mode_in = MODE_SKIP;
                     end else begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
                  MODE_SKIP: begin
                     mode_in = MODE_IDLE;
                  end
                  MODE_DATE: begin
                     date_in = put_char(date_ff, idx_ff, rx_byte);
                     if (idx_ff == LAST_SLOT) begin
                        idx_in  = '0;
                        mode_in = MODE_IDLE;
                        done_in = 1'b1;
                     end else begin
                        idx_in = idx_ff + IDX_W'(1);
                     end
                  end
                  default: begin
                     if (rx_byte == CHAR_COMMA) begin
                        comma_in = comma_ff + COMMA_W'(1);
                     end else if (comma_ff == TIME_FIELD && !taken_ff) begin
                        time_in  = put_char(time_ff, '0, rx_byte);
                        idx_in   = IDX_W'(1);
                        mode_in  = MODE_TIME;
                        taken_in = 1'b1;
                     end else if (comma_ff == DATE_FIELD) begin
                        date_in = put_char(date_ff, '0, rx_byte);
                        idx_in  = IDX_W'(1);
                        mode_in = MODE_DATE;
                     end
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      result.time_chars        = time_ff;
      result.date_chars        = date_ff;
      result.sentence_accepted = hm_ff && (pos_ff >= POS_W'(HEAD_LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         hm_ff    <= 1'b1;
         comma_ff <= '0;
         taken_ff <= 1'b0;
         mode_ff  <= MODE_IDLE;
         idx_ff   <= '0;
         done_ff  <= 1'b0;
         time_ff  <= STORE_RESET;
         date_ff  <= STORE_RESET;
      end else begin
         pos_ff   <= pos_in;
         hm_ff    <= hm_in;
         comma_ff <= comma_in;
         taken_ff <= taken_in;
         mode_ff  <= mode_in;
         idx_ff   <= idx_in;
         done_ff  <= done_in;
         time_ff  <= time_in;
         date_ff  <= date_in;
      end
   end

   `ASSERT_IMPLY(a_done_idle, clock, reset, done_ff, mode_ff == MODE_IDLE)
   `ASSERT_IMPLY(a_idx_mode, clock, reset, idx_ff != '0, mode_ff == MODE_TIME || mode_ff == MODE_DATE)
   `ASSERT_IMPLY(a_pos_limit, clock, reset, 1'b1, pos_ff <= POS_W'(LINE_LIMIT))
   `ASSERT_NEXT(a_lf_clears, clock, reset, step && is_lf, pos_ff == '0 && hm_ff && !done_ff)

endmodule

// ===== src/nmea_rmc_time_date_extractor.sv =====
// Top level: input register, parser core and result register with handshakes
// Takes one received byte per clock unless a line feed waits. A byte is registered before
// the core parses it; a line feed that advances loads the core's result into the result
// register, which presents the time/date transaction. Bytes other than a line feed never wait;
// a line feed waits in the input register only while the prior result is still held on rsp_.
module nmea_rmc_time_date_extractor import nmea_rmc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [CHAR_W-1:0]  req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STORE_W-1:0] rsp_time_chars,
   output logic [STORE_W-1:0] rsp_date_chars,
   output logic               rsp_sentence_accepted
);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] byte_ff,     byte_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff,       out_in;
   result_type        core_result;
   logic              is_lf;
   logic              advance;

   assign is_lf   = (byte_ff == CHAR_LF);
   assign advance = in_valid_ff && (!is_lf || !out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   nmea_rmc_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (byte_ff),
      .result  (core_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      byte_in     = byte_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         byte_in     = req_rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (advance && is_lf) begin
         out_valid_in = 1'b1;
         out_in       = core_result;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      byte_ff <= byte_in;
      out_ff  <= out_in;
   end

   assign rsp_valid             = out_valid_ff;
   assign rsp_time_chars        = out_ff.time_chars;
   assign rsp_date_chars        = out_ff.date_chars;
   assign rsp_sentence_accepted = out_ff.sentence_accepted;

endmodule
